// ===== rtl/swu_pkg.sv =====
// ----------------------------------------------------------------------------
// swu_pkg
// Shared constants, register codes, tables and structs of the SARPROP
// weight update pipeline.
// ----------------------------------------------------------------------------
package swu_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 24;
	localparam int STEP_BITS  = 31;
	localparam int ITER_BITS  = 24;
	localparam int RND_BITS   = 24;
	localparam int TAB_FRAC   = 24;
	localparam int ADDR_BITS  = 5;
	localparam int POW_STEPS  = 8;
	localparam int NUM_STAGES = 14;

	localparam int ST_S1    = 0;
	localparam int ST_S2    = 1;
	localparam int ST_POW   = 2;
	localparam int ST_SHIFT = ST_POW + POW_STEPS;
	localparam int ST_MUL   = ST_SHIFT + 1;
	localparam int ST_SIGN  = ST_MUL + 1;
	localparam int ST_OUT   = ST_SIGN + 1;

	localparam logic [FRAC_BITS:0]   FIX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [STEP_BITS-1:0] STEP_MAX = '1;
	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// 2^-(2^-(i+1)) in Q0.24 for entry i, one entry per fraction bit of the exponent
	localparam logic [TAB_FRAC-1:0] POW_TAB [POW_STEPS] = '{
		24'd11863283, 24'd14107901, 24'd15384775, 24'd16065917,
		24'd16417715, 24'd16596571, 24'd16686609, 24'd16731851
	};

	typedef enum logic [2:0] {
		REG_SHRINK = 3'd0,
		REG_GROW   = 3'd1,
		REG_FLOOR  = 3'd2,
		REG_CEIL   = 3'd3,
		REG_DECAY  = 3'd4,
		REG_NTHR   = 3'd5,
		REG_NOISE  = 3'd6,
		REG_ANNEAL = 3'd7
	} swu_reg_t;

	localparam logic [24:0] RST_SHRINK = 25'd8388608;
	localparam logic [25:0] RST_GROW   = 26'd20132659;
	localparam logic [24:0] RST_FLOOR  = 25'd168;
	localparam logic [30:0] RST_CEIL   = 31'd83886080;
	localparam logic [24:0] RST_DECAY  = 25'd167772;
	localparam logic [24:0] RST_NTHR   = 25'd1677722;
	localparam logic [28:0] RST_NOISE  = 29'd50331648;
	localparam logic [24:0] RST_ANNEAL = 25'd167772;

	typedef enum logic [1:0] {
		UPD_SAME   = 2'd0,
		UPD_FLIP   = 2'd1,
		UPD_HOLD   = 2'd2,
		UPD_FROZEN = 2'd3
	} swu_upd_t;

	typedef struct packed {
		logic [24:0] shrink;
		logic [25:0] grow;
		logic [24:0] step_floor;
		logic [30:0] step_ceiling;
		logic [24:0] k1;
		logic [24:0] k2;
		logic [28:0] k3;
		logic [24:0] temp;
	} swu_cfg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] valid;
	} swu_pipe_t;

	typedef struct packed {
		logic [FRAC_BITS:0] p;
		logic [7:0]         xf;
		logic [4:0]         xi;
		logic               xbig;
	} swu_pow_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] w;
		logic [WORD_BITS-1:0] g;
		logic [WORD_BITS-1:0] gp;
		logic [STEP_BITS-1:0] step;
		logic                 frozen;
		logic [31:0]          dm;
		logic [38:0]          ahk;
		logic [24:0]          alkh;
		logic [28:0]          nz0;
		logic [STEP_BITS-1:0] grown;
		logic [STEP_BITS-1:0] shrunk;
		logic                 shr_sat;
	} swu_carry_t;

endpackage

// ===== rtl/swu_rec_if.sv =====
// ----------------------------------------------------------------------------
// swu_rec_if
// Weight record channel: valid/ready handshake with the record payload.
// ----------------------------------------------------------------------------
interface swu_rec_if import swu_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] weight_in;
	logic signed [WORD_BITS-1:0] gradient;
	logic signed [WORD_BITS-1:0] prior_gradient;
	logic [STEP_BITS-1:0]        step_in;
	logic                        frozen;
	logic [STEP_BITS-1:0]        net_error;
	logic [ITER_BITS-1:0]        iteration;
	logic [RND_BITS-1:0]         random_value;

	modport source (
		output valid, weight_in, gradient, prior_gradient, step_in, frozen,
		       net_error, iteration, random_value,
		input  ready
	);
	modport sink (
		input  valid, weight_in, gradient, prior_gradient, step_in, frozen,
		       net_error, iteration, random_value,
		output ready
	);
endinterface

// ===== rtl/swu_res_if.sv =====
// ----------------------------------------------------------------------------
// swu_res_if
// Update result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface swu_res_if import swu_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] weight_out;
	logic signed [WORD_BITS-1:0] applied_change;
	logic [STEP_BITS-1:0]        step_out;
	logic signed [WORD_BITS-1:0] gradient_to_keep;
	logic                        saturated;

	modport source (
		output valid, weight_out, applied_change, step_out, gradient_to_keep, saturated,
		input  ready
	);
	modport sink (
		input  valid, weight_out, applied_change, step_out, gradient_to_keep, saturated,
		output ready
	);
endinterface

// ===== rtl/swu_regs.sv =====
// ----------------------------------------------------------------------------
// swu_regs
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module swu_regs import swu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  index,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output swu_cfg_t    cfg
);

	swu_cfg_t cfg_q;
	swu_reg_t sel;
	logic     wr;

	assign sel = swu_reg_t'(index);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shrink       <= RST_SHRINK;
			cfg_q.grow         <= RST_GROW;
			cfg_q.step_floor   <= RST_FLOOR;
			cfg_q.step_ceiling <= RST_CEIL;
			cfg_q.k1           <= RST_DECAY;
			cfg_q.k2           <= RST_NTHR;
			cfg_q.k3           <= RST_NOISE;
			cfg_q.temp         <= RST_ANNEAL;
		end else if (wr) begin
			case (sel)
				REG_SHRINK: cfg_q.shrink       <= pwdata[24:0];
				REG_GROW:   cfg_q.grow         <= pwdata[25:0];
				REG_FLOOR:  cfg_q.step_floor   <= pwdata[24:0];
				REG_CEIL:   cfg_q.step_ceiling <= pwdata[30:0];
				REG_DECAY:  cfg_q.k1           <= pwdata[24:0];
				REG_NTHR:   cfg_q.k2           <= pwdata[24:0];
				REG_NOISE:  cfg_q.k3           <= pwdata[28:0];
				REG_ANNEAL: cfg_q.temp         <= pwdata[24:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (sel)
			REG_SHRINK: prdata = {7'd0, cfg_q.shrink};
			REG_GROW:   prdata = {6'd0, cfg_q.grow};
			REG_FLOOR:  prdata = {7'd0, cfg_q.step_floor};
			REG_CEIL:   prdata = {1'b0, cfg_q.step_ceiling};
			REG_DECAY:  prdata = {7'd0, cfg_q.k1};
			REG_NTHR:   prdata = {7'd0, cfg_q.k2};
			REG_NOISE:  prdata = {3'd0, cfg_q.k3};
			REG_ANNEAL: prdata = {7'd0, cfg_q.temp};
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/swu_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// swu_pipe_ctrl
// Stage valid bits and per-stage load enables; bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module swu_pipe_ctrl import swu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	output swu_pipe_t ctl
);

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] en;

	// a stage holds only when it and every later stage are full and the sink stalls
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
		assign en[i] = out_ready || !(&valid_q[NUM_STAGES-1:i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign ctl.en    = en;
	assign ctl.valid = valid_q;

endmodule

// ===== rtl/swu_front.sv =====
// ----------------------------------------------------------------------------
// swu_front
// Stages 1-2: input products, step grow/shrink limits, error threshold parts.
// ----------------------------------------------------------------------------
module swu_front import swu_pkg::*; (
	input  logic                 clk,
	input  swu_pipe_t            ctl,
	input  swu_cfg_t             cfg,
	input  logic [WORD_BITS-1:0] weight_in,
	input  logic [WORD_BITS-1:0] gradient,
	input  logic [WORD_BITS-1:0] prior_gradient,
	input  logic [STEP_BITS-1:0] step_in,
	input  logic                 frozen,
	input  logic [STEP_BITS-1:0] net_error,
	input  logic [ITER_BITS-1:0] iteration,
	input  logic [RND_BITS-1:0]  random_value,
	output swu_pow_t             pow,
	output swu_carry_t           carry
);

	logic [WORD_BITS-1:0] wmag;

	logic [48:0]          x_s1;
	logic [56:0]          wk_s1;
	logic [61:0]          e2_s1;
	logic [52:0]          kr_s1;
	logic [56:0]          gr_s1;
	logic [55:0]          sh_s1;
	logic [WORD_BITS-1:0] w_s1;
	logic [WORD_BITS-1:0] g_s1;
	logic [WORD_BITS-1:0] gp_s1;
	logic [STEP_BITS-1:0] step_s1;
	logic                 frz_s1;

	logic [13:0]          ah;
	logic [23:0]          al;
	logic [48:0]          alk;
	logic [32:0]          gr;
	logic [31:0]          sh;
	logic [31:0]          shf;

	swu_pow_t             pow_s2;
	swu_carry_t           carry_s2;

	assign wmag = weight_in[WORD_BITS-1] ? (~weight_in + 32'd1) : weight_in;

	always_ff @(posedge clk) begin
		if (ctl.en[ST_S1]) begin
			x_s1    <= 49'(cfg.temp) * 49'(iteration);
			wk_s1   <= 57'(wmag) * 57'(cfg.k1);
			e2_s1   <= 62'(net_error) * 62'(net_error);
			kr_s1   <= 53'(cfg.k3) * 53'(random_value);
			gr_s1   <= 57'(step_in) * 57'(cfg.grow);
			sh_s1   <= 56'(step_in) * 56'(cfg.shrink);
			w_s1    <= weight_in;
			g_s1    <= gradient;
			gp_s1   <= prior_gradient;
			step_s1 <= step_in;
			frz_s1  <= frozen;
		end
	end

	assign ah  = e2_s1[61:2*FRAC_BITS];
	assign al  = e2_s1[2*FRAC_BITS-1:FRAC_BITS];
	assign alk = 49'(al) * 49'(cfg.k2);
	assign gr  = gr_s1[56:FRAC_BITS];
	assign sh  = sh_s1[55:FRAC_BITS];
	assign shf = (sh < 32'(cfg.step_floor)) ? 32'(cfg.step_floor) : sh;

	always_ff @(posedge clk) begin
		if (ctl.en[ST_S2]) begin
			pow_s2.p    <= FIX_ONE;
			pow_s2.xf   <= x_s1[FRAC_BITS-8 +: 8];
			pow_s2.xi   <= x_s1[FRAC_BITS +: 5];
			pow_s2.xbig <= |x_s1[48:FRAC_BITS+5];

			carry_s2.w       <= w_s1;
			carry_s2.g       <= g_s1;
			carry_s2.gp      <= gp_s1;
			carry_s2.step    <= step_s1;
			carry_s2.frozen  <= frz_s1;
			carry_s2.dm      <= wk_s1[FRAC_BITS +: 32];
			carry_s2.ahk     <= 39'(ah) * 39'(cfg.k2);
			carry_s2.alkh    <= alk[48:TAB_FRAC];
			carry_s2.nz0     <= kr_s1[RND_BITS +: 29];
			carry_s2.grown   <= (gr > 33'(cfg.step_ceiling)) ? cfg.step_ceiling
			                                               : gr[STEP_BITS-1:0];
			carry_s2.shrunk  <= shf[31] ? STEP_MAX : shf[STEP_BITS-1:0];
			carry_s2.shr_sat <= shf[31];
		end
	end

	assign pow   = pow_s2;
	assign carry = carry_s2;

endmodule

// ===== rtl/swu_pow.sv =====
// ----------------------------------------------------------------------------
// swu_pow
// Stages 3-11: annealing factor 2^-x, one truncating multiply per fraction
// bit of x, then the integer shift.
// ----------------------------------------------------------------------------
module swu_pow import swu_pkg::*; (
	input  logic               clk,
	input  swu_pipe_t          ctl,
	input  swu_pow_t           pow,
	input  swu_carry_t         carry_in,
	output logic [FRAC_BITS:0] factor,
	output swu_carry_t         carry_out
);

	swu_pow_t           pw_s  [POW_STEPS];
	swu_carry_t         cr_s  [POW_STEPS+1];
	logic [FRAC_BITS:0] fac_s11;

	for (genvar k = 0; k < POW_STEPS; k++) begin : g_step
		swu_pow_t                    src;
		swu_pow_t                    nxt;
		swu_carry_t                  csrc;
		logic [FRAC_BITS+TAB_FRAC:0] prod;

		if (k == 0) begin : g_first
			assign src  = pow;
			assign csrc = carry_in;
		end else begin : g_next
			assign src  = pw_s[k-1];
			assign csrc = cr_s[k-1];
		end

		assign prod = (FRAC_BITS+TAB_FRAC+1)'(src.p) * (FRAC_BITS+TAB_FRAC+1)'(POW_TAB[k]);

		always_comb begin
			nxt = src;
			if (src.xf[POW_STEPS-1-k]) begin
				nxt.p = prod[TAB_FRAC +: FRAC_BITS+1];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en[ST_POW+k]) begin
				pw_s[k] <= nxt;
				cr_s[k] <= csrc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_SHIFT]) begin
			fac_s11 <= pw_s[POW_STEPS-1].xbig ? '0
			                                  : pw_s[POW_STEPS-1].p >> pw_s[POW_STEPS-1].xi;
			cr_s[POW_STEPS] <= cr_s[POW_STEPS-1];
		end
	end

	assign factor    = fac_s11;
	assign carry_out = cr_s[POW_STEPS];

endmodule

// ===== rtl/swu_back.sv =====
// ----------------------------------------------------------------------------
// swu_back
// Stages 12-14: decay and noise products, gradient reduction and case
// select, weight add with saturation.
// ----------------------------------------------------------------------------
module swu_back import swu_pkg::*; (
	input  logic                 clk,
	input  swu_pipe_t            ctl,
	input  logic [FRAC_BITS:0]   factor,
	input  swu_carry_t           carry,
	output logic [WORD_BITS-1:0] weight_out,
	output logic [WORD_BITS-1:0] applied_change,
	output logic [STEP_BITS-1:0] step_out,
	output logic [WORD_BITS-1:0] gradient_to_keep,
	output logic                 saturated
);

	logic [56:0]          dec_prod;
	logic [53:0]          nz_prod;
	logic [39:0]          thr;

	logic [31:0]          dec_s12;
	logic [29:0]          nz_s12;
	logic                 lt_s12;
	swu_carry_t           cr_s12;

	logic [33:0]          g_x;
	logic [33:0]          d_x;
	logic [33:0]          diff;
	logic                 ovf;
	logic [WORD_BITS-1:0] gsat;
	logic                 gpos;
	logic                 gneg;
	logic                 ppos;
	logic                 pneg;
	logic [31:0]          noisy;
	logic [STEP_BITS-1:0] noisy_step;
	swu_upd_t             kind;
	logic [STEP_BITS-1:0] step_nx;
	logic [WORD_BITS-1:0] gkeep_nx;
	logic                 sat_nx;

	swu_upd_t             kind_s13;
	logic [STEP_BITS-1:0] step_s13;
	logic [WORD_BITS-1:0] gkeep_s13;
	logic                 sat_s13;
	logic                 neg_s13;
	logic [WORD_BITS-1:0] w_s13;

	logic [32:0]          delta;
	logic [32:0]          sum;
	logic                 wovf;

	logic [WORD_BITS-1:0] wout_s14;
	logic [WORD_BITS-1:0] chg_s14;
	logic [STEP_BITS-1:0] step_s14;
	logic [WORD_BITS-1:0] gkeep_s14;
	logic                 sat_s14;

	assign dec_prod = 57'(carry.dm) * 57'(factor);
	assign nz_prod  = 54'(carry.nz0) * 54'(factor);
	assign thr      = 40'(carry.ahk) + 40'(carry.alkh);

	always_ff @(posedge clk) begin
		if (ctl.en[ST_MUL]) begin
			dec_s12 <= dec_prod[FRAC_BITS +: 32];
			nz_s12  <= nz_prod[FRAC_BITS +: 30];
			lt_s12  <= 40'(carry.shrunk) < thr;
			cr_s12  <= carry;
		end
	end

	assign g_x  = {{2{cr_s12.g[WORD_BITS-1]}}, cr_s12.g};
	assign d_x  = {2'b00, dec_s12};
	// decay takes the sign of the weight
	assign diff = cr_s12.w[WORD_BITS-1] ? (g_x + d_x) : (g_x - d_x);
	assign ovf  = (diff[33:31] != 3'b000) && (diff[33:31] != 3'b111);
	assign gsat = ovf ? (diff[33] ? WORD_MIN : WORD_MAX) : diff[WORD_BITS-1:0];
	assign gneg = diff[33];
	assign gpos = !diff[33] && (diff != '0);
	assign pneg = cr_s12.gp[WORD_BITS-1];
	assign ppos = !cr_s12.gp[WORD_BITS-1] && (cr_s12.gp != '0);

	assign noisy      = 32'(cr_s12.shrunk) + 32'(nz_s12);
	assign noisy_step = noisy[31] ? STEP_MAX : noisy[STEP_BITS-1:0];

	always_comb begin
		if (cr_s12.frozen) begin
			kind = UPD_FROZEN;
		end else if ((gpos && ppos) || (gneg && pneg)) begin
			kind = UPD_SAME;
		end else if ((gpos && pneg) || (gneg && ppos)) begin
			kind = UPD_FLIP;
		end else begin
			kind = UPD_HOLD;
		end
	end

	always_comb begin
		case (kind)
			UPD_SAME: begin
				step_nx  = cr_s12.grown;
				gkeep_nx = gsat;
				sat_nx   = ovf;
			end
			UPD_FLIP: begin
				step_nx  = lt_s12 ? noisy_step : cr_s12.shrunk;
				gkeep_nx = '0;
				sat_nx   = ovf || cr_s12.shr_sat || (lt_s12 && noisy[31]);
			end
			UPD_HOLD: begin
				step_nx  = cr_s12.step;
				gkeep_nx = gsat;
				sat_nx   = ovf;
			end
			default: begin
				step_nx  = cr_s12.step;
				gkeep_nx = cr_s12.g;
				sat_nx   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_SIGN]) begin
			kind_s13  <= kind;
			step_s13  <= step_nx;
			gkeep_s13 <= gkeep_nx;
			sat_s13   <= sat_nx;
			neg_s13   <= gsat[WORD_BITS-1];
			w_s13     <= cr_s12.w;
		end
	end

	always_comb begin
		if (kind_s13 inside {UPD_FLIP, UPD_FROZEN}) begin
			delta = '0;
		end else if (neg_s13) begin
			delta = 33'd0 - 33'(step_s13);
		end else begin
			delta = 33'(step_s13);
		end
	end

	assign sum  = {w_s13[WORD_BITS-1], w_s13} + delta;
	assign wovf = sum[32] != sum[31];

	always_ff @(posedge clk) begin
		if (ctl.en[ST_OUT]) begin
			wout_s14  <= wovf ? (sum[32] ? WORD_MIN : WORD_MAX) : sum[WORD_BITS-1:0];
			chg_s14   <= delta[WORD_BITS-1:0];
			step_s14  <= step_s13;
			gkeep_s14 <= gkeep_s13;
			sat_s14   <= sat_s13 || wovf;
		end
	end

	assign weight_out       = wout_s14;
	assign applied_change   = chg_s14;
	assign step_out         = step_s14;
	assign gradient_to_keep = gkeep_s14;
	assign saturated        = sat_s14;

endmodule

// ===== rtl/sarprop_weight_update.sv =====
// ----------------------------------------------------------------------------
// sarprop_weight_update
// SARPROP weight update, Q8.24 fixed point. The block takes one weight record
// per clock unless the pipeline is full and the result is held, and returns
// results in order; a held result stalls only the stages behind it, so empty
// stages still take new beats. The depth is set by the 2^-(T*iteration) factor:
// eight dependent truncating multiplies, one per fraction bit, each in its own
// stage, plus the integer shift. Configuration is written over the APB port at
// byte address 4*index and takes effect for records accepted after the write.
// ----------------------------------------------------------------------------
module sarprop_weight_update import swu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	swu_rec_if.sink              rec,
	swu_res_if.source            res
);

	swu_cfg_t   cfg;
	swu_pipe_t  ctl;
	swu_pow_t   pow;
	swu_carry_t carry_s2;
	swu_carry_t carry_s11;
	logic [FRAC_BITS:0] factor;
	logic [WORD_BITS-1:0] weight_out;
	logic [WORD_BITS-1:0] applied_change;
	logic [WORD_BITS-1:0] gradient_to_keep;

	assign pready = 1'b1;

	swu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.index   (paddr[ADDR_BITS-1:2]),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	swu_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rec.valid),
		.out_ready (res.ready),
		.ctl       (ctl)
	);

	assign rec.ready = ctl.en[ST_S1];
	assign res.valid = ctl.valid[ST_OUT];

	swu_front u_front (
		.clk            (clk),
		.ctl            (ctl),
		.cfg            (cfg),
		.weight_in      (rec.weight_in),
		.gradient       (rec.gradient),
		.prior_gradient (rec.prior_gradient),
		.step_in        (rec.step_in),
		.frozen         (rec.frozen),
		.net_error      (rec.net_error),
		.iteration      (rec.iteration),
		.random_value   (rec.random_value),
		.pow            (pow),
		.carry          (carry_s2)
	);

	swu_pow u_pow (
		.clk       (clk),
		.ctl       (ctl),
		.pow       (pow),
		.carry_in  (carry_s2),
		.factor    (factor),
		.carry_out (carry_s11)
	);

	swu_back u_back (
		.clk              (clk),
		.ctl              (ctl),
		.factor           (factor),
		.carry            (carry_s11),
		.weight_out       (weight_out),
		.applied_change   (applied_change),
		.step_out         (res.step_out),
		.gradient_to_keep (gradient_to_keep),
		.saturated        (res.saturated)
	);

	assign res.weight_out       = $signed(weight_out);
	assign res.applied_change   = $signed(applied_change);
	assign res.gradient_to_keep = $signed(gradient_to_keep);

`ifndef NO_ASSERTIONS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> rec.ready)
		else $error("record channel stalled with an empty output stage");

	a_beat_enters: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid && rec.ready |=> ctl.valid[ST_S1])
		else $error("accepted record beat not held in the first stage");

	a_change_is_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.applied_change != 0) |->
			(res.applied_change == {1'b0, res.step_out}) ||
			(res.applied_change == (32'd0 - {1'b0, res.step_out})))
		else $error("applied change differs from the reported step");
`endif

endmodule
